/* sv/sintay_pkg.sv */
// Shared widths, types and constants for the fixed-point sine series pipeline.
// Depends on nothing; every other file imports it.
package sintay_pkg;

   localparam int unsigned ANGLE_BITS = 32;
   localparam int unsigned TERM_BITS  = 48;

   // The angle is split into a signed upper half and an unsigned lower half
   // so that each partial product stays at 48 by 17 bits or less.
   localparam int unsigned XL_BITS    = 16;
   localparam int unsigned MUL_LAT    = 2;

   // Division by a small constant works on one 16-bit digit at a time. The
   // remainder stays below the divisor, which is under 2^11 for every step.
   localparam int unsigned DIGIT_BITS = 16;
   localparam int unsigned DIGITS     = TERM_BITS / DIGIT_BITS;
   localparam int unsigned REM_BITS   = 11;
   localparam int unsigned NUM_BITS   = REM_BITS + DIGIT_BITS;
   localparam int unsigned RECIP_BITS = NUM_BITS + 1;
   localparam int unsigned PROD_BITS  = NUM_BITS + RECIP_BITS;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [TERM_BITS-1:0]  term_type;

   // What travels alongside each request from stage to stage.
   typedef struct packed {
      logic      valid;
      angle_type angle;
      term_type  sum;
   } sintay_lane_type;

endpackage

/* sv/sine_taylor_series.sv */
// Sine of a signed Q3.28 angle by the Maclaurin series x - x^3/3! + ..., with
// TERM_STEPS terms after x, returned in signed Q3.28 and saturated to 32 bits.
// A request is taken in every cycle in which start is high; busy never rises.
// Each result appears on rsp_sine_value for one cycle with rsp_strobe high, in
// request order. A request passes an input register, then the term steps,
// each of which holds two two-stage multipliers, a magnitude stage, a
// three-digit reciprocal divider of two stages a digit, and an accumulate
// stage, and then an output register. The receiver cannot stall.
// Depends on sintay_pkg and sintay_step.
module sine_taylor_series
   import sintay_pkg::*;
#(
   parameter int unsigned TERM_STEPS    = 10,
   parameter int unsigned FRACTION_BITS = 28
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  angle_type req_angle,
   output logic      rsp_strobe,
   output angle_type rsp_sine_value
);

   localparam angle_type SAT_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
   localparam angle_type SAT_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   sintay_lane_type lane_chain  [TERM_STEPS+1];
   term_type        nterm_chain [TERM_STEPS+1];

   sintay_lane_type lane0_in, lane0_ff;
   term_type        nterm0_in, nterm0_ff;
   term_type        final_sum;
   logic            fits;
   angle_type       value_in, value_ff;
   logic            strobe_ff;

   assign busy = 1'b0;

   always_comb begin
      lane0_in.valid = start;
      lane0_in.angle = req_angle;
      lane0_in.sum   = TERM_BITS'(req_angle);
      nterm0_in      = -TERM_BITS'(req_angle);
   end

   assign lane_chain[0]  = lane0_ff;
   assign nterm_chain[0] = nterm0_ff;

   for (genvar s = 0; s < TERM_STEPS; s++) begin : g_step
      sintay_step #(
         .STEP          (s + 1),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .up_lane  (lane_chain[s]),
         .up_nterm (nterm_chain[s]),
         .dn_lane  (lane_chain[s+1]),
         .dn_nterm (nterm_chain[s+1])
      );
   end

   // The sum fits in 32 bits when its upper bits all copy the sign bit.
   assign final_sum = lane_chain[TERM_STEPS].sum;
   assign fits = (final_sum[TERM_BITS-1:ANGLE_BITS-1] == '0) ||
                 (final_sum[TERM_BITS-1:ANGLE_BITS-1] == '1);

   always_comb begin
      if (fits) begin
         value_in = final_sum[ANGLE_BITS-1:0];
      end else if (final_sum[TERM_BITS-1]) begin
         value_in = SAT_MIN;
      end else begin
         value_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane0_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         lane0_ff  <= lane0_in;
         strobe_ff <= lane_chain[TERM_STEPS].valid;
      end
      nterm0_ff <= nterm0_in;
      value_ff  <= value_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_sine_value = value_ff;

endmodule

/* sv/sintay_mulq.sv */
// Two-stage fixed-point multiply: floor(a * x / 2^FRACTION_BITS), kept to 48 bits.
// Depends on sintay_pkg.
module sintay_mulq
   import sintay_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 28
) (
   input  logic     clock,
   input  term_type a,
   input  angle_type x,
   output term_type product
);

   localparam int unsigned HI_BITS   = ANGLE_BITS - XL_BITS;
   localparam int unsigned P_HI_BITS = TERM_BITS + HI_BITS;
   localparam int unsigned WIDE_BITS = TERM_BITS + XL_BITS + 1;
   localparam int unsigned SHIFT     = FRACTION_BITS - XL_BITS;

   logic signed [HI_BITS-1:0]   xh;
   logic signed [XL_BITS:0]     xl;
   logic signed [P_HI_BITS-1:0] p_hi_in, p_hi_ff;
   logic signed [WIDE_BITS-1:0] p_lo_in, p_lo_ff;
   logic signed [WIDE_BITS-1:0] comb_sum, comb_shift;
   term_type                    product_in, product_ff;

   assign xh      = x[ANGLE_BITS-1:XL_BITS];
   assign xl      = {1'b0, x[XL_BITS-1:0]};
   assign p_hi_in = a * xh;
   assign p_lo_in = a * xl;

   // The upper partial product carries weight 2^16, so the lower one is
   // shifted down before the two are added.
   assign comb_sum   = WIDE_BITS'(p_hi_ff) + (p_lo_ff >>> XL_BITS);
   assign comb_shift = comb_sum >>> SHIFT;
   assign product_in = comb_shift[TERM_BITS-1:0];

   always_ff @(posedge clock) begin
      p_hi_ff    <= p_hi_in;
      p_lo_ff    <= p_lo_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

/* sv/sintay_step.sv */
// One series step: the next term is -term * x * x / ((2i)(2i+1)), added to the sum.
// Depends on sintay_pkg and sintay_mulq.
module sintay_step
   import sintay_pkg::*;
#(
   parameter int unsigned STEP          = 1,
   parameter int unsigned FRACTION_BITS = 28
) (
   input  logic            clock,
   input  logic            reset,
   input  sintay_lane_type up_lane,
   input  term_type        up_nterm,
   output sintay_lane_type dn_lane,
   output term_type        dn_nterm
);

   localparam int unsigned DIVISOR     = (2 * STEP) * (2 * STEP + 1);
   localparam int unsigned DIV_LOG     = $clog2(DIVISOR);
   localparam int unsigned RECIP_SHIFT = NUM_BITS + DIV_LOG;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
   localparam int unsigned LANE_DEPTH  = 2 * MUL_LAT + 1 + 2 * DIGITS;

   sintay_lane_type lane_ff [LANE_DEPTH];

   term_type t1, t2;

   logic [TERM_BITS-1:0] mag_in;

   // Entry 0 of each digit array is the magnitude stage; entry d + 1 is the
   // result of digit d.
   logic [TERM_BITS-1:0] b_mag_ff  [DIGITS+1];
   logic [TERM_BITS-1:0] b_quot_ff [DIGITS+1];
   logic [REM_BITS-1:0]  b_rem_ff  [DIGITS+1];
   logic                 b_neg_ff  [DIGITS+1];

   logic [NUM_BITS-1:0]  a_n_in    [DIGITS];
   logic [PROD_BITS-1:0] a_prod_in [DIGITS];
   logic [NUM_BITS-1:0]  a_n_ff    [DIGITS];
   logic [PROD_BITS-1:0] a_prod_ff [DIGITS];
   logic [TERM_BITS-1:0] a_mag_ff  [DIGITS];
   logic [TERM_BITS-1:0] a_quot_ff [DIGITS];
   logic                 a_neg_ff  [DIGITS];

   logic [TERM_BITS-1:0] b_quot_in [DIGITS];
   logic [REM_BITS-1:0]  b_rem_in  [DIGITS];

   sintay_lane_type lane_out_in, lane_out_ff;
   term_type        nterm_out_in, nterm_out_ff;
   term_type        quot_s;

   sintay_mulq #(.FRACTION_BITS(FRACTION_BITS)) u_mul_first (
      .clock   (clock),
      .a       (up_nterm),
      .x       (up_lane.angle),
      .product (t1)
   );

   sintay_mulq #(.FRACTION_BITS(FRACTION_BITS)) u_mul_second (
      .clock   (clock),
      .a       (t1),
      .x       (lane_ff[MUL_LAT-1].angle),
      .product (t2)
   );

   assign mag_in = t2[TERM_BITS-1] ? (~t2 + 1'b1) : t2;

   // Each digit divides remainder:digit by the constant with a reciprocal
   // multiply that is exact for numerators below 2^NUM_BITS.
   always_comb begin
      logic [PROD_BITS-1:0] shifted;
      logic [DIGIT_BITS-1:0] q;
      logic [NUM_BITS-1:0]  back;
      logic [NUM_BITS-1:0]  diff;
      for (int d = 0; d < DIGITS; d++) begin
         a_n_in[d]    = {b_rem_ff[d], b_mag_ff[d][TERM_BITS-1-d*DIGIT_BITS -: DIGIT_BITS]};
         a_prod_in[d] = PROD_BITS'(a_n_in[d]) * PROD_BITS'(RECIP);
         shifted      = a_prod_ff[d] >> RECIP_SHIFT;
         q            = shifted[DIGIT_BITS-1:0];
         back         = NUM_BITS'(q) * NUM_BITS'(DIVISOR);
         diff         = a_n_ff[d] - back;
         b_rem_in[d]  = diff[REM_BITS-1:0];
         b_quot_in[d] = a_quot_ff[d];
         b_quot_in[d][TERM_BITS-1-d*DIGIT_BITS -: DIGIT_BITS] = q;
      end
   end

   // A term of negative sign is subtracted, and the negated term for the next
   // step then has the quotient's own sign.
   assign quot_s = b_quot_ff[DIGITS];

   always_comb begin
      lane_out_in = lane_ff[LANE_DEPTH-1];
      if (b_neg_ff[DIGITS]) begin
         lane_out_in.sum = lane_ff[LANE_DEPTH-1].sum - quot_s;
         nterm_out_in    = quot_s;
      end else begin
         lane_out_in.sum = lane_ff[LANE_DEPTH-1].sum + quot_s;
         nterm_out_in    = -quot_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LANE_DEPTH; j++) begin
            lane_ff[j] <= '0;
         end
         lane_out_ff <= '0;
      end else begin
         lane_ff[0] <= up_lane;
         for (int j = 1; j < LANE_DEPTH; j++) begin
            lane_ff[j] <= lane_ff[j-1];
         end
         lane_out_ff <= lane_out_in;
      end

      b_mag_ff[0]  <= mag_in;
      b_neg_ff[0]  <= t2[TERM_BITS-1];
      b_rem_ff[0]  <= '0;
      b_quot_ff[0] <= '0;
      for (int d = 0; d < DIGITS; d++) begin
         a_n_ff[d]      <= a_n_in[d];
         a_prod_ff[d]   <= a_prod_in[d];
         a_mag_ff[d]    <= b_mag_ff[d];
         a_quot_ff[d]   <= b_quot_ff[d];
         a_neg_ff[d]    <= b_neg_ff[d];
         b_mag_ff[d+1]  <= a_mag_ff[d];
         b_quot_ff[d+1] <= b_quot_in[d];
         b_rem_ff[d+1]  <= b_rem_in[d];
         b_neg_ff[d+1]  <= a_neg_ff[d];
      end

      nterm_out_ff <= nterm_out_in;
   end

   assign dn_lane  = lane_out_ff;
   assign dn_nterm = nterm_out_ff;

endmodule

/* tb/tb.sv */
// Self-checking bench for sine_taylor_series: angles go in through the start/busy port and
// every sine result is compared with a bit-exact series computed here in the bench.
// Depends on sintay_pkg and the sine_taylor_series RTL.
module tb;
   import sintay_pkg::*;

   localparam int unsigned SERIES_STEPS  = 10;
   localparam int unsigned FRACTION_BITS = 28;
   localparam int unsigned PIPE_LATENCY  = 12 * SERIES_STEPS + 2;
   localparam int unsigned RANDOM_ANGLES = 900;
   localparam int unsigned STALL_LIMIT   = 4000;

   localparam angle_type ONE_RAD = 32'sd268435456;
   localparam angle_type HALF_PI = 32'sd421657428;
   localparam angle_type PI_RAD  = 32'sd843314857;
   localparam angle_type TWO_PI  = 32'sd1686629713;

   typedef struct {
      angle_type angle;
      angle_type sine;
   } sine_expect_type;

   logic      clock;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   angle_type req_angle = '0;
   logic      rsp_strobe;
   angle_type rsp_sine_value;

   angle_type       pending_angles[$];
   sine_expect_type expected_sines[$];

   logic        request_taken = 1'b0;
   int unsigned gap_left      = 0;
   int unsigned burst_left    = 0;
   int unsigned requests_sent = 0;
   int unsigned results_seen  = 0;
   int unsigned saturated     = 0;
   int unsigned mismatches    = 0;
   int unsigned quiet_cycles  = 0;

   sine_taylor_series #(
      .TERM_STEPS    (SERIES_STEPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_angle      (req_angle),
      .rsp_strobe     (rsp_strobe),
      .rsp_sine_value (rsp_sine_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Keeps the low 48 bits and sign-extends them, as the term registers do.
   function automatic longint wrap_term(longint v);
      return {{16{v[TERM_BITS-1]}}, v[TERM_BITS-1:0]};
   endfunction

   // Floor of a * x / 2^FRACTION_BITS, built from the split halves of x.
   function automatic longint scaled_product(longint a, longint x);
      longint xh;
      longint xl;
      longint s;
      xh = x >>> XL_BITS;
      xl = x & 64'hFFFF;
      s  = a * xh + ((a * xl) >>> XL_BITS);
      return wrap_term(s >>> (FRACTION_BITS - XL_BITS));
   endfunction

   function automatic angle_type sine_series(angle_type angle);
      longint x;
      longint term;
      longint sum;
      longint divisor;
      x    = longint'(angle);
      term = x;
      sum  = x;
      for (int i = 1; i <= SERIES_STEPS; i++) begin
         divisor = (2 * i) * (2 * i + 1);
         term = wrap_term(-term);
         term = scaled_product(term, x);
         term = scaled_product(term, x);
         // Division on longint truncates toward zero, as required.
         term = wrap_term(term / divisor);
         sum  = wrap_term(sum + term);
      end
      if (sum > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (sum < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return sum[ANGLE_BITS-1:0];
   endfunction

   // Driver: a request stays on the port until it is taken, then a gap may follow.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !request_taken) begin
         start <= 1'b1;
      end else if (gap_left != 0) begin
         gap_left <= gap_left - 1;
         start    <= 1'b0;
      end else if (pending_angles.size() != 0) begin
         req_angle <= pending_angles.pop_front();
         start     <= 1'b1;
         if (burst_left != 0) begin
            burst_left <= burst_left - 1;
            gap_left   <= 0;
         end else if ($urandom_range(0, 99) < 5) begin
            burst_left <= $urandom_range(20, 80);
            gap_left   <= 0;
         end else if ($urandom_range(0, 99) < 55) begin
            gap_left <= 0;
         end else if ($urandom_range(0, 99) < 85) begin
            gap_left <= $urandom_range(1, 3);
         end else begin
            gap_left <= $urandom_range(4, 40);
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Acceptance of requests and prediction of their results.
   always @(posedge clock) begin
      if (reset) begin
         request_taken <= 1'b0;
      end else begin
         request_taken <= start && !busy;
         if (start && !busy) begin
            expected_sines.push_back('{angle: req_angle, sine: sine_series(req_angle)});
            requests_sent <= requests_sent + 1;
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      sine_expect_type oldest;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (expected_sines.size() == 0) begin
            mismatches <= mismatches + 1;
            $display("%0t: unexpected result, expected none, actual %0d",
                     $time, rsp_sine_value);
         end else begin
            oldest = expected_sines.pop_front();
            if (oldest.sine == 32'sh7FFFFFFF || oldest.sine == 32'sh80000000) begin
               saturated <= saturated + 1;
            end
            if (rsp_sine_value !== oldest.sine) begin
               mismatches <= mismatches + 1;
               $display("%0t: sine of angle %0d, expected %0d, actual %0d",
                        $time, oldest.angle, oldest.sine, rsp_sine_value);
            end
         end
      end
   end

   // Watchdog on cycles in which neither a request nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  expected_sines.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      angle_type directed[$];
      int unsigned pick;
      directed = {32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
                  ONE_RAD, -ONE_RAD, HALF_PI, -HALF_PI, PI_RAD, -PI_RAD,
                  TWO_PI, -TWO_PI, 32'sh40000000, -32'sh40000000,
                  32'sh78000000, -32'sh78000000, 32'sh0000FFFF, 32'sh00010000,
                  32'shFFFF0000, 32'shFFFF8000, 32'sh55555555, 32'shAAAAAAAA};
      foreach (directed[i]) begin
         pending_angles.push_back(directed[i]);
      end
      // Mostly full-range and one-turn angles, where saturation and the
      // usable range both get exercised, with some tiny ones in between.
      repeat (RANDOM_ANGLES) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            pending_angles.push_back($urandom);
         end else if (pick < 80) begin
            pending_angles.push_back($urandom_range(0, 2 * TWO_PI) - TWO_PI);
         end else begin
            pending_angles.push_back($urandom_range(0, 32'h00200000) - 32'h00100000);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_angles.size() != 0 || start || expected_sines.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_LATENCY + 20) @(posedge clock);

      $display("Sent %0d angles and checked %0d sine results, %0d of them saturated.",
               requests_sent, results_seen, saturated);
      $display("Mismatches found: %0d.", mismatches);
      if (mismatches == 0 && expected_sines.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
